@@ hw/rtl/timecode_cue_fade_engine_assert.svh @@
`ifndef TIMECODE_CUE_FADE_ENGINE_ASSERT_SVH
`define TIMECODE_CUE_FADE_ENGINE_ASSERT_SVH
// Same-cycle implication, checked on clk, quiet during rst.
`define TCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on clk, quiet during rst.
`define TCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hw/rtl/tcf_pkg.sv @@
`timescale 1ns / 1ps
package tcf_pkg;

  typedef enum logic [1:0] {
    OP_HEADER   = 2'd0,
    OP_ENTRY    = 2'd1,
    OP_TIMECODE = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  localparam logic [1:0] CFG_FRAME_RATE = 2'd0;
  localparam logic [1:0] CFG_CUE_TOTAL  = 2'd1;
  localparam logic [1:0] CFG_LOOP_JUMP  = 2'd2;

  localparam logic [5:0]  FRAME_RATE_RST = 6'd30;
  localparam logic [8:0]  CUE_TOTAL_RST  = 9'd0;
  localparam logic [22:0] LOOP_JUMP_RST  = 23'd50;

  localparam logic KIND_LEVEL = 1'b0;
  localparam logic KIND_CUE   = 1'b1;

  localparam int unsigned TC_SEC_HOUR = 3600;
  localparam int unsigned TC_SEC_MIN  = 60;

  localparam int QDEPTH = 2;
  localparam int QPW    = 1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  cue_slot;
    logic [3:0]  entry_slot;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [5:0]  frames;
    logic [31:0] fade_ms;
    logic [4:0]  channel_count;
    logic [9:0]  channel;
    logic [7:0]  level;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [9:0] out_channel;
    logic [7:0] out_level;
    logic [7:0] cue_number;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [5:0]  frame_rate;
    logic [8:0]  cue_total;
    logic [22:0] loop_jump_frames;
  } cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    op_t        op;
    logic       load_ok;
    logic       ch_ok;
    logic [4:0] count;
    item_t      item;
  } qitem_t;

  typedef struct packed {
    logic [22:0] time_frames;
    logic [31:0] fade_ms;
    logic [4:0]  count;
  } cue_t;

  typedef struct packed {
    logic [9:0] channel;
    logic [7:0] level;
  } entry_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  level;
    logic [7:0]  from_lvl;
    logic [7:0]  to_lvl;
    logic [31:0] begin_ms;
    logic [31:0] len_ms;
  } chan_t;

endpackage

@@ hw/rtl/tcf_ram.sv @@
`timescale 1ns / 1ps
module tcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/tcf_front.sv @@
`timescale 1ns / 1ps
module tcf_front #(
  parameter int CUE_DEPTH       = 256,
  parameter int ENTRIES_PER_CUE = 16,
  parameter int CHANNEL_COUNT   = 512
) (
  input  tcf_pkg::item_t  item,
  input  logic            item_valid,
  output logic            item_stall,
  input  logic            clearing,
  input  logic            q_full,
  output logic            push,
  output tcf_pkg::qitem_t push_data
);
  logic slot_ok;

  assign item_stall = q_full || clearing;
  assign push       = item_valid && !item_stall;
  assign slot_ok    = 32'(item.cue_slot) < CUE_DEPTH;

  always_comb begin
    push_data      = '0;
    push_data.item = item;
    push_data.op   = tcf_pkg::op_t'(item.opcode);
    push_data.ch_ok = (item.channel != 10'd0) && (32'(item.channel) <= CHANNEL_COUNT);
    push_data.count = (32'(item.channel_count) > ENTRIES_PER_CUE) ?
                      5'(ENTRIES_PER_CUE) : item.channel_count;
    case (tcf_pkg::op_t'(item.opcode))
      tcf_pkg::OP_HEADER: push_data.load_ok = slot_ok;
      tcf_pkg::OP_ENTRY:  push_data.load_ok = slot_ok &&
                                              (32'(item.entry_slot) < ENTRIES_PER_CUE);
      default:            push_data.load_ok = 1'b0;
    endcase
  end
endmodule

@@ hw/rtl/tcf_queue.sv @@
`timescale 1ns / 1ps
`include "timecode_cue_fade_engine_assert.svh"
module tcf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcf_pkg::qitem_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output tcf_pkg::qitem_t pop_data
);
  tcf_pkg::qitem_t             slots [tcf_pkg::QDEPTH];
  logic [tcf_pkg::QPW-1:0]     wptr;
  logic [tcf_pkg::QPW-1:0]     rptr;
  logic [tcf_pkg::QPW:0]       count;

  assign full     = count == (tcf_pkg::QPW + 1)'(tcf_pkg::QDEPTH);
  assign q_valid  = count != '0;
  assign pop_data = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= push_data;
        wptr        <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TCF_ASSERT_NOW(a_no_push_full, full && !pop, !push, "queue pushed while full")
endmodule

@@ hw/rtl/tcf_back.sv @@
`timescale 1ns / 1ps
`include "timecode_cue_fade_engine_assert.svh"
module tcf_back #(
  parameter int CUE_DEPTH       = 256,
  parameter int ENTRIES_PER_CUE = 16,
  parameter int CHANNEL_COUNT   = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  tcf_pkg::cfg_t    cfg,
  input  logic             restart,
  input  logic             q_valid,
  input  tcf_pkg::qitem_t  q_data,
  output logic             q_pop,
  output logic             clearing,
  output tcf_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);
  localparam int CW = CUE_DEPTH > 1 ? $clog2(CUE_DEPTH) : 1;
  localparam int EW = ENTRIES_PER_CUE > 1 ? $clog2(ENTRIES_PER_CUE) : 1;
  localparam int KW = CHANNEL_COUNT > 1 ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SW = CW + 1;
  localparam int CUE_RAM_DEPTH = 1 << CW;
  localparam int ENT_RAM_DEPTH = 1 << (CW + EW);
  localparam int CH_RAM_DEPTH  = 1 << KW;
  localparam int CUE_W = $bits(tcf_pkg::cue_t);
  localparam int ENT_W = $bits(tcf_pkg::entry_t);
  localparam int CH_W  = $bits(tcf_pkg::chan_t);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_TC1, S_TC2, S_TC3,
    S_SCAN_A, S_SCAN_D, S_SCAN_END, S_CUE_D, S_ENT_A, S_ENT_D, S_CH_D,
    S_TK_D, S_MUL, S_SUM, S_DIV, S_TK_W, S_EMIT
  } state_t;

  state_t            state;
  logic [KW-1:0]     clr;
  tcf_pkg::qitem_t   cur;
  logic [16:0]       secs;
  logic [22:0]       total;
  logic [22:0]       prev;
  logic              cur_valid;
  logic [CW-1:0]     cur_idx;
  logic              found;
  logic [CW-1:0]     idx;
  logic [SW-1:0]     si;
  logic [SW-1:0]     limit;
  logic [4:0]        ne;
  logic [31:0]       fade_len;
  logic [4:0]        ei;
  logic [9:0]        ech;
  logic [7:0]        ev;
  logic [KW-1:0]     ck;
  tcf_pkg::chan_t    chw;
  logic [31:0]       el;
  logic [39:0]       p1;
  logic [39:0]       p2;
  logic [39:0]       rem;
  logic [2:0]        dcnt;
  logic [7:0]        quo;
  tcf_pkg::result_t  pend;

  // RAM ports
  logic                cue_we;
  logic [CW-1:0]       cue_waddr;
  logic [CW-1:0]       cue_raddr;
  tcf_pkg::cue_t       cue_wdata;
  tcf_pkg::cue_t       cue_rd;
  logic                ent_we;
  logic [CW+EW-1:0]    ent_waddr;
  logic [CW+EW-1:0]    ent_raddr;
  tcf_pkg::entry_t     ent_wdata;
  tcf_pkg::entry_t     ent_rd;
  logic                ch_we;
  logic [KW-1:0]       ch_waddr;
  logic [KW-1:0]       ch_raddr;
  tcf_pkg::chan_t      ch_wdata;
  tcf_pkg::chan_t      ch_rd;

  logic                ent_ok;
  logic [31:0]         el_c;
  logic                done_c;
  logic [39:0]         dsub;
  logic                ge;
  logic                load;

  assign clearing = state == S_CLEAR;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign load     = (state == S_EMIT) && (!result_valid || !result_stall);

  assign cue_we    = (state == S_TC3) && (cur.op == tcf_pkg::OP_HEADER) && cur.load_ok;
  assign cue_waddr = CW'(cur.item.cue_slot);
  assign cue_wdata = '{time_frames: total, fade_ms: cur.item.fade_ms, count: cur.count};
  assign cue_raddr = (state == S_SCAN_A) ? si[CW-1:0] : idx;

  assign ent_we    = (state == S_DISPATCH) && (cur.op == tcf_pkg::OP_ENTRY) && cur.load_ok;
  assign ent_waddr = {CW'(cur.item.cue_slot), EW'(cur.item.entry_slot)};
  assign ent_wdata = '{channel: cur.item.channel, level: cur.item.level};
  assign ent_raddr = {idx, ei[EW-1:0]};
  assign ent_ok    = (ent_rd.channel != 10'd0) && (32'(ent_rd.channel) <= CHANNEL_COUNT);

  assign ch_raddr = (state == S_ENT_D) ? KW'(ent_rd.channel - 10'd1)
                                       : KW'(cur.item.channel - 10'd1);
  assign el_c     = cur.item.now_ms - ch_rd.begin_ms;
  assign done_c   = el_c >= ch_rd.len_ms;

  assign dsub = 40'(chw.len_ms) << dcnt;
  assign ge   = rem >= dsub;

  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = ck;
    ch_wdata = ch_rd;
    case (state)
      S_CLEAR: begin
        ch_we    = 1'b1;
        ch_waddr = clr;
        ch_wdata = '0;
      end
      S_CH_D: begin
        ch_we = 1'b1;
        if (fade_len == 32'd0) begin
          ch_wdata.active = 1'b0;
          ch_wdata.level  = ev;
        end else begin
          ch_wdata.active   = 1'b1;
          ch_wdata.from_lvl = ch_rd.level;
          ch_wdata.to_lvl   = ev;
          ch_wdata.begin_ms = cur.item.now_ms;
          ch_wdata.len_ms   = fade_len;
        end
      end
      S_TK_D: begin
        ch_we           = ch_rd.active && done_c;
        ch_wdata.active = 1'b0;
        ch_wdata.level  = ch_rd.to_lvl;
      end
      S_TK_W: begin
        ch_we          = 1'b1;
        ch_wdata       = chw;
        ch_wdata.level = quo;
      end
      default: ch_we = 1'b0;
    endcase
  end

  tcf_ram #(.WIDTH(CUE_W), .DEPTH(CUE_RAM_DEPTH)) u_cue_ram (
    .clk(clk), .we(cue_we), .waddr(cue_waddr), .wdata(cue_wdata),
    .raddr(cue_raddr), .rdata(cue_rd)
  );

  tcf_ram #(.WIDTH(ENT_W), .DEPTH(ENT_RAM_DEPTH)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(ent_raddr), .rdata(ent_rd)
  );

  tcf_ram #(.WIDTH(CH_W), .DEPTH(CH_RAM_DEPTH)) u_ch_ram (
    .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
    .raddr(ch_raddr), .rdata(ch_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr          <= '0;
      cur_valid    <= 1'b0;
      prev         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        result       <= pend;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == CHANNEL_COUNT - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_data;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (cur.op)
            tcf_pkg::OP_HEADER, tcf_pkg::OP_TIMECODE: state <= S_TC1;
            tcf_pkg::OP_ENTRY:                        state <= S_IDLE;
            default: begin
              ck    <= ch_raddr;
              state <= cur.ch_ok ? S_TK_D : S_IDLE;
            end
          endcase
        end
        S_TC1: begin
          secs  <= 17'(cur.item.hours) * 17'(tcf_pkg::TC_SEC_HOUR)
                 + 17'(cur.item.minutes) * 17'(tcf_pkg::TC_SEC_MIN)
                 + 17'(cur.item.seconds);
          state <= S_TC2;
        end
        S_TC2: begin
          total <= 23'(24'(secs) * 24'(cfg.frame_rate) + 24'(cur.item.frames));
          state <= S_TC3;
        end
        S_TC3: begin
          if (cur.op == tcf_pkg::OP_HEADER) begin
            state <= S_IDLE;
          end else begin
            if (cur_valid && (({1'b0, total} + {1'b0, cfg.loop_jump_frames}) < {1'b0, prev}))
            begin
              cur_valid <= 1'b0;
            end
            prev  <= total;
            si    <= '0;
            found <= 1'b0;
            idx   <= '0;
            limit <= (32'(cfg.cue_total) > CUE_DEPTH) ? SW'(CUE_DEPTH) : SW'(cfg.cue_total);
            state <= S_SCAN_A;
          end
        end
        S_SCAN_A: begin
          state <= (si >= limit) ? S_SCAN_END : S_SCAN_D;
        end
        S_SCAN_D: begin
          if (cue_rd.time_frames <= total) begin
            found <= 1'b1;
            idx   <= si[CW-1:0];
            si    <= si + 1'b1;
            state <= S_SCAN_A;
          end else begin
            state <= S_SCAN_END;
          end
        end
        S_SCAN_END: begin
          if (found && !(cur_valid && cur_idx == idx)) begin
            cur_valid <= 1'b1;
            cur_idx   <= idx;
            state     <= S_CUE_D;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CUE_D: begin
          ne       <= cue_rd.count;
          fade_len <= cue_rd.fade_ms;
          ei       <= '0;
          state    <= S_ENT_A;
        end
        S_ENT_A: begin
          if (ei >= ne) begin
            pend  <= '{kind: tcf_pkg::KIND_CUE, out_channel: 10'd0, out_level: 8'd0,
                       cue_number: 8'(idx), last: 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_ENT_D;
          end
        end
        S_ENT_D: begin
          if (ent_ok) begin
            ech   <= ent_rd.channel;
            ev    <= ent_rd.level;
            ck    <= ch_raddr;
            state <= S_CH_D;
          end else begin
            ei    <= ei + 1'b1;
            state <= S_ENT_A;
          end
        end
        S_CH_D: begin
          if (fade_len == 32'd0) begin
            pend  <= '{kind: tcf_pkg::KIND_LEVEL, out_channel: ech, out_level: ev,
                       cue_number: 8'd0, last: 1'b0};
            state <= S_EMIT;
          end else begin
            ei    <= ei + 1'b1;
            state <= S_ENT_A;
          end
        end
        S_TK_D: begin
          chw <= ch_rd;
          el  <= el_c;
          if (!ch_rd.active) begin
            state <= S_IDLE;
          end else if (done_c) begin
            pend  <= '{kind: tcf_pkg::KIND_LEVEL, out_channel: cur.item.channel,
                       out_level: ch_rd.to_lvl, cue_number: 8'd0, last: 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // from*(len-elapsed) + to*elapsed equals the signed form and stays >= 0
          p1    <= {32'd0, chw.from_lvl} * {8'd0, chw.len_ms - el};
          p2    <= {32'd0, chw.to_lvl} * {8'd0, el};
          state <= S_SUM;
        end
        S_SUM: begin
          rem   <= p1 + p2;
          dcnt  <= 3'd7;
          quo   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // quotient is below 256: eight restoring steps, MSB first
          if (ge) begin
            rem <= rem - dsub;
          end
          quo  <= {quo[6:0], ge};
          dcnt <= dcnt - 1'b1;
          if (dcnt == 3'd0) begin
            state <= S_TK_W;
          end
        end
        S_TK_W: begin
          pend  <= '{kind: tcf_pkg::KIND_LEVEL, out_channel: cur.item.channel,
                     out_level: quo, cue_number: 8'd0, last: 1'b1};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            if (pend.last) begin
              state <= S_IDLE;
            end else begin
              ei    <= ei + 1'b1;
              state <= S_ENT_A;
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      if (restart) begin
        cur_valid <= 1'b0;
      end
    end
  end

  `TCF_ASSERT_NEXT(a_pop_dispatch, q_pop, state == S_DISPATCH, "popped item not dispatched")
  `TCF_ASSERT_NEXT(a_last_idle, load && pend.last, state == S_IDLE, "final item not closed")
endmodule

@@ hw/rtl/timecode_cue_fade_engine.sv @@
`timescale 1ns / 1ps
// Timecode cue engine with per-channel linear fades. Items are loads of cue
// headers and channel entries, timecode items and fade ticks; results are
// channel levels and cue-fired notices, the last one of an item flagged.
// After reset all CHANNEL_COUNT channel-store entries (512 by default) are
// cleared before the first item is taken; config writes are taken at all
// times. Items are taken one at a time by the back-end sequencer; a two-item
// queue lets the input side run ahead. An entry load writes the entry store;
// a header load converts its timecode and writes the cue store. A tick ends
// at once for an idle or bad channel, snaps an ended fade to its target, or
// interpolates a fade in progress through the eight-step divider. A timecode
// item scans the cue store, one read and compare per cue, and on a new cue
// applies its entries (skipped, fade started or level snapped). Every result
// waits in its state for as long as result_stall holds it back.
module timecode_cue_fade_engine #(
  parameter int CUE_DEPTH       = 256,
  parameter int ENTRIES_PER_CUE = 16,
  parameter int CHANNEL_COUNT   = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  tcf_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_stall,
  output tcf_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [22:0]      cfg_data
);
  tcf_pkg::cfg_t   cfg;
  logic            restart;
  logic            clearing;
  logic            q_full;
  logic            push;
  tcf_pkg::qitem_t push_data;
  logic            q_valid;
  logic            q_pop;
  tcf_pkg::qitem_t q_data;

  assign cfg_ready = 1'b1;
  // writing the cue count forgets the current cue
  assign restart   = cfg_valid && (cfg_index == tcf_pkg::CFG_CUE_TOTAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_rate       <= tcf_pkg::FRAME_RATE_RST;
      cfg.cue_total        <= tcf_pkg::CUE_TOTAL_RST;
      cfg.loop_jump_frames <= tcf_pkg::LOOP_JUMP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcf_pkg::CFG_FRAME_RATE: cfg.frame_rate       <= cfg_data[5:0];
        tcf_pkg::CFG_CUE_TOTAL:  cfg.cue_total        <= cfg_data[8:0];
        tcf_pkg::CFG_LOOP_JUMP:  cfg.loop_jump_frames <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: classify and range-check
  tcf_front #(
    .CUE_DEPTH(CUE_DEPTH), .ENTRIES_PER_CUE(ENTRIES_PER_CUE), .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_front (
    .item(item), .item_valid(item_valid), .item_stall(item_stall),
    .clearing(clearing), .q_full(q_full), .push(push), .push_data(push_data)
  );

  tcf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(q_full),
    .pop(q_pop), .q_valid(q_valid), .pop_data(q_data)
  );

  // back: cue scan, apply, fades, result register
  tcf_back #(
    .CUE_DEPTH(CUE_DEPTH), .ENTRIES_PER_CUE(ENTRIES_PER_CUE), .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .restart(restart),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .clearing(clearing),
    .result(result), .result_valid(result_valid), .result_stall(result_stall)
  );
endmodule
